// ===== rtl/qfv_pkg.sv =====
// Shared constants and types for the quaternion-from-two-vectors pipeline.
`timescale 1ns / 1ps
package qfv_pkg;
	localparam int FRAC_BITS = 14;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int ROOT_W    = 32;
	localparam int RAD_W     = 64;
	localparam int REM_W     = 34;
	localparam int NUM_W     = ROOT_W + FRAC_BITS;
	localparam int SQ_STAGES = 32;
	localparam int MAG_W     = 34;
	localparam int NORM_W    = 31;
	localparam int POS_W     = 6;
	localparam int NORM_TOP  = 30;
	localparam int SCALE_TOP = 14;
	localparam logic [19:0] OPP_SCALE = 20'd1000000;
	localparam int USR_OPP = 0;
	localparam int USR_DEG = 1;

	typedef struct packed {
		logic signed [33:0] dot;
		logic signed [32:0] cx;
		logic signed [32:0] cy;
		logic signed [32:0] cz;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
		logic               deg;
	} geo_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       opp;
		logic       deg;
	} meta_t;

	typedef struct packed {
		meta_t                   meta;
		logic [3:0][NORM_W-1:0] mag;
	} nrm_t;
endpackage

// ===== rtl/qfv_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module qfv_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qfv_pkg::RAD_W-1:0]  rad,
	output logic [qfv_pkg::ROOT_W-1:0] root
);
	logic [qfv_pkg::SQ_STAGES-1:0][qfv_pkg::REM_W-1:0]  rem_s;
	logic [qfv_pkg::SQ_STAGES-1:0][qfv_pkg::ROOT_W-1:0] root_s;
	logic [qfv_pkg::SQ_STAGES-1:0][qfv_pkg::RAD_W-1:0]  rad_s;

	for (genvar k = 0; k < qfv_pkg::SQ_STAGES; k++) begin : g_st
		logic [qfv_pkg::REM_W-1:0]  pr;
		logic [qfv_pkg::ROOT_W-1:0] pt;
		logic [qfv_pkg::RAD_W-1:0]  px;
		logic [qfv_pkg::REM_W+1:0]  acc;
		logic [qfv_pkg::REM_W+1:0]  trial;
		if (k == 0) begin : g_first
			assign pr = '0;
			assign pt = '0;
			assign px = rad;
		end else begin : g_next
			assign pr = rem_s[k-1];
			assign pt = root_s[k-1];
			assign px = rad_s[k-1];
		end
		assign acc   = {pr, px[qfv_pkg::RAD_W-1 -: 2]};
		assign trial = {2'b00, pt, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {px[qfv_pkg::RAD_W-3:0], 2'b00};
				if (acc >= trial) begin
					rem_s[k]  <= qfv_pkg::REM_W'(acc - trial);
					root_s[k] <= {pt[qfv_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= acc[qfv_pkg::REM_W-1:0];
					root_s[k] <= {pt[qfv_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[qfv_pkg::SQ_STAGES-1];
endmodule

// ===== rtl/qfv_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qfv_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  qfv_pkg::meta_t                      in_meta,
	input  logic [3:0][qfv_pkg::NUM_W-1:0]      num,
	input  logic [qfv_pkg::ROOT_W-1:0]          den,
	output logic                                out_valid,
	output qfv_pkg::meta_t                      out_meta,
	output logic [3:0][qfv_pkg::QUO_W-1:0]      quo
);
	logic [qfv_pkg::QUO_W-1:0]                              vld_s;
	qfv_pkg::meta_t [qfv_pkg::QUO_W-1:0]                    meta_s;
	logic [qfv_pkg::QUO_W-1:0][qfv_pkg::ROOT_W-1:0]         den_s;
	logic [qfv_pkg::QUO_W-1:0][3:0][qfv_pkg::NUM_W-1:0]     rem_s;
	logic [qfv_pkg::QUO_W-1:0][3:0][qfv_pkg::QUO_W-1:0]     quo_s;

	for (genvar k = 0; k < qfv_pkg::QUO_W; k++) begin : g_st
		logic                              pv;
		qfv_pkg::meta_t                    pm;
		logic [qfv_pkg::ROOT_W-1:0]        pd;
		logic [3:0][qfv_pkg::NUM_W-1:0]    pr;
		logic [3:0][qfv_pkg::QUO_W-1:0]    pq;
		logic [qfv_pkg::NUM_W-1:0]         dsh;
		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign pm = in_meta;
			assign pd = den;
			assign pr = num;
			assign pq = '0;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pm = meta_s[k-1];
			assign pd = den_s[k-1];
			assign pr = rem_s[k-1];
			assign pq = quo_s[k-1];
		end
		assign dsh = {{(qfv_pkg::NUM_W-qfv_pkg::ROOT_W){1'b0}}, pd} << (qfv_pkg::QUO_W-1-k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= pm;
				den_s[k]  <= pd;
				for (int l = 0; l < 4; l++) begin
					if (pr[l] >= dsh) begin
						rem_s[k][l] <= pr[l] - dsh;
						quo_s[k][l] <= {pq[l][qfv_pkg::QUO_W-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= pr[l];
						quo_s[k][l] <= {pq[l][qfv_pkg::QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[qfv_pkg::QUO_W-1];
	assign out_meta  = meta_s[qfv_pkg::QUO_W-1];
	assign quo       = quo_s[qfv_pkg::QUO_W-1];
endmodule

// ===== rtl/quaternion_from_two_vectors_unit.sv =====
// Top level: unit quaternion rotating vector u onto vector v, fully pipelined.
//
//  channel  dir  tdata (low bit up)                               tuser
//  s_       in   first_x, first_y, first_z, second_x..z  16b each  -
//  m_       out  quat_real, quat_i, quat_j, quat_k       16b each  opposite_case, degenerate
//
//  One item per cycle unless the output stalls: 3 front stages, 32-stage square root of the
//  norm product, 7 stages (real part, opposite test, branch select, leading one, normalize,
//  squares, sum), second 32-stage square root, 15 quotient-bit stages, output register.
//  Reset clears all valid bits. A stall at the output holds every stage at once.
`timescale 1ns / 1ps
module quaternion_from_two_vectors_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // first_x, first_y, first_z, second_x, second_y, second_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // quat_real, quat_i, quat_j, quat_k
	output logic [1:0]  m_tuser   // opposite_case, degenerate
);
	function automatic logic [3:0] scale_sh(input logic [15:0] orv);
		logic [3:0] sh;
		sh = 4'd0;
		for (int i = 0; i < qfv_pkg::SCALE_TOP; i++) begin
			if (orv[i]) sh = 4'(qfv_pkg::SCALE_TOP - i);
		end
		if (orv[15:14] != 2'b00) sh = 4'd0;
		return sh;
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] a);
		return a[15] ? 16'(-a) : 16'(a);
	endfunction

	logic adv;
	logic out_vld_q;
	logic [63:0] out_data_q;
	logic [1:0]  out_user_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// scale
	logic signed [15:0] in_u [3];
	logic signed [15:0] in_v [3];
	logic [3:0] shu, shv;
	logic [15:0] oru, orv;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_u[i] = s_tdata[16*i +: 16];
			in_v[i] = s_tdata[48 + 16*i +: 16];
		end
		oru = mag16(in_u[0]) | mag16(in_u[1]) | mag16(in_u[2]);
		orv = mag16(in_v[0]) | mag16(in_v[1]) | mag16(in_v[2]);
		shu = scale_sh(oru);
		shv = scale_sh(orv);
	end

	logic vld_s1;
	logic signed [15:0] u_s1 [3];
	logic signed [15:0] v_s1 [3];
	logic deg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= in_u[i] <<< shu;
				v_s1[i] <= in_v[i] <<< shv;
			end
			deg_s1 <= (oru == 16'd0) || (orv == 16'd0);
		end
	end

	// dot, cross, squared lengths
	logic vld_s2;
	logic [31:0] uu_s2, vv_s2;
	qfv_pkg::geo_t geo_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s2 <= $unsigned(32'(u_s1[0]) * 32'(u_s1[0]) + 32'(u_s1[1]) * 32'(u_s1[1])
				+ 32'(u_s1[2]) * 32'(u_s1[2]));
			vv_s2 <= $unsigned(32'(v_s1[0]) * 32'(v_s1[0]) + 32'(v_s1[1]) * 32'(v_s1[1])
				+ 32'(v_s1[2]) * 32'(v_s1[2]));
			geo_s2.dot <= 34'(u_s1[0]) * 34'(v_s1[0]) + 34'(u_s1[1]) * 34'(v_s1[1])
				+ 34'(u_s1[2]) * 34'(v_s1[2]);
			geo_s2.cx  <= 33'(u_s1[1]) * 33'(v_s1[2]) - 33'(u_s1[2]) * 33'(v_s1[1]);
			geo_s2.cy  <= 33'(u_s1[2]) * 33'(v_s1[0]) - 33'(u_s1[0]) * 33'(v_s1[2]);
			geo_s2.cz  <= 33'(u_s1[0]) * 33'(v_s1[1]) - 33'(u_s1[1]) * 33'(v_s1[0]);
			geo_s2.ux  <= u_s1[0];
			geo_s2.uy  <= u_s1[1];
			geo_s2.uz  <= u_s1[2];
			geo_s2.deg <= deg_s1;
		end
	end

	// norm product
	logic vld_s3;
	logic [63:0] prod_s3;
	qfv_pkg::geo_t geo_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= 64'(uu_s2) * 64'(vv_s2);
			geo_s3  <= geo_s2;
		end
	end

	logic [qfv_pkg::ROOT_W-1:0] n_root;
	qfv_isqrt u_sqrt_norm (
		.clk  (clk),
		.en   (adv),
		.rad  (prod_s3),
		.root (n_root)
	);

	logic [qfv_pkg::SQ_STAGES-1:0] vld_dl1;
	qfv_pkg::geo_t geo_dl1 [qfv_pkg::SQ_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_dl1[0] <= geo_s3;
			for (int k = 1; k < qfv_pkg::SQ_STAGES; k++) geo_dl1[k] <= geo_dl1[k-1];
		end
	end

	// real part
	logic vld_s4;
	logic signed [34:0] real_s4;
	logic [31:0] n_s4;
	qfv_pkg::geo_t geo_s4;
	qfv_pkg::geo_t geo_end1;
	assign geo_end1 = geo_dl1[qfv_pkg::SQ_STAGES-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			real_s4 <= $signed({3'b000, n_root}) + 35'(geo_end1.dot);
			n_s4    <= n_root;
			geo_s4  <= geo_end1;
		end
	end

	// opposite test product
	logic vld_s5;
	logic signed [54:0] oprod_s5;
	logic signed [34:0] real_s5;
	logic [31:0] n_s5;
	qfv_pkg::geo_t geo_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			oprod_s5 <= 55'(real_s4) * 55'($signed({1'b0, qfv_pkg::OPP_SCALE}));
			real_s5  <= real_s4;
			n_s5     <= n_s4;
			geo_s5   <= geo_s4;
		end
	end

	// branch select
	logic opp_d;
	logic signed [34:0] qv [4];
	always_comb begin
		opp_d = oprod_s5 < $signed({23'd0, n_s5});
		if (opp_d) begin
			qv[0] = '0;
			if ({1'b0, mag16(geo_s5.ux)} > {1'b0, mag16(geo_s5.uz)}) begin
				qv[1] = -35'(geo_s5.uy);
				qv[2] = 35'(geo_s5.ux);
				qv[3] = '0;
			end else begin
				qv[1] = '0;
				qv[2] = -35'(geo_s5.uz);
				qv[3] = 35'(geo_s5.uy);
			end
		end else begin
			qv[0] = real_s5;
			qv[1] = 35'(geo_s5.cx);
			qv[2] = 35'(geo_s5.cy);
			qv[3] = 35'(geo_s5.cz);
		end
	end

	logic vld_s6;
	qfv_pkg::meta_t meta_s6;
	logic [3:0][qfv_pkg::MAG_W-1:0] mag_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				meta_s6.neg[i] <= qv[i][34];
				mag_s6[i]      <= qv[i][34] ? qfv_pkg::MAG_W'(-qv[i]) : qfv_pkg::MAG_W'(qv[i]);
			end
			meta_s6.opp <= opp_d;
			meta_s6.deg <= geo_s5.deg;
		end
	end

	// leading one of the largest magnitude
	logic [qfv_pkg::MAG_W-1:0] mor;
	logic [qfv_pkg::POS_W-1:0] pos_d;
	always_comb begin
		mor   = mag_s6[0] | mag_s6[1] | mag_s6[2] | mag_s6[3];
		pos_d = '0;
		for (int i = 0; i < qfv_pkg::MAG_W; i++) begin
			if (mor[i]) pos_d = qfv_pkg::POS_W'(i);
		end
	end

	logic vld_s7;
	qfv_pkg::meta_t meta_s7;
	logic [3:0][qfv_pkg::MAG_W-1:0] mag_s7;
	logic [qfv_pkg::POS_W-1:0] pos_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s7 <= meta_s6;
			mag_s7  <= mag_s6;
			pos_s7  <= pos_d;
		end
	end

	// block normalize
	logic vld_s8;
	qfv_pkg::nrm_t nrm_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s8.meta <= meta_s7;
			for (int i = 0; i < 4; i++) begin
				if (pos_s7 > qfv_pkg::POS_W'(qfv_pkg::NORM_TOP)) begin
					nrm_s8.mag[i] <= qfv_pkg::NORM_W'(mag_s7[i]
						>> (pos_s7 - qfv_pkg::POS_W'(qfv_pkg::NORM_TOP)));
				end else begin
					nrm_s8.mag[i] <= qfv_pkg::NORM_W'(mag_s7[i]
						<< (qfv_pkg::POS_W'(qfv_pkg::NORM_TOP) - pos_s7));
				end
			end
		end
	end

	// squares
	logic vld_s9;
	qfv_pkg::nrm_t nrm_s9;
	logic [3:0][2*qfv_pkg::NORM_W-1:0] sq_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s9 <= nrm_s8;
			for (int i = 0; i < 4; i++) begin
				sq_s9[i] <= (2*qfv_pkg::NORM_W)'(nrm_s8.mag[i])
					* (2*qfv_pkg::NORM_W)'(nrm_s8.mag[i]);
			end
		end
	end

	// sum of squares
	logic vld_s10;
	qfv_pkg::nrm_t nrm_s10;
	logic [63:0] sum_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s10 <= nrm_s9;
			sum_s10 <= 64'(sq_s9[0]) + 64'(sq_s9[1]) + 64'(sq_s9[2]) + 64'(sq_s9[3]);
		end
	end

	logic [qfv_pkg::ROOT_W-1:0] len_root;
	qfv_isqrt u_sqrt_len (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s10),
		.root (len_root)
	);

	logic [qfv_pkg::SQ_STAGES-1:0] vld_dl2;
	qfv_pkg::nrm_t nrm_dl2 [qfv_pkg::SQ_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_dl2[0] <= nrm_s10;
			for (int k = 1; k < qfv_pkg::SQ_STAGES; k++) nrm_dl2[k] <= nrm_dl2[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_dl1 <= '0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_dl2 <= '0;
		end else if (adv) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_dl1 <= {vld_dl1[qfv_pkg::SQ_STAGES-2:0], vld_s3};
			vld_s4  <= vld_dl1[qfv_pkg::SQ_STAGES-1];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_dl2 <= {vld_dl2[qfv_pkg::SQ_STAGES-2:0], vld_s10};
		end
	end

	// division
	qfv_pkg::nrm_t nrm_end2;
	logic [3:0][qfv_pkg::NUM_W-1:0] num_d;
	assign nrm_end2 = nrm_dl2[qfv_pkg::SQ_STAGES-1];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num_d[i] = (qfv_pkg::NUM_W'(nrm_end2.mag[i]) << qfv_pkg::FRAC_BITS)
				+ qfv_pkg::NUM_W'(len_root >> 1);
		end
	end

	logic div_vld;
	qfv_pkg::meta_t div_meta;
	logic [3:0][qfv_pkg::QUO_W-1:0] div_quo;
	qfv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_dl2[qfv_pkg::SQ_STAGES-1]),
		.in_meta   (nrm_end2.meta),
		.num       (num_d),
		.den       (len_root),
		.out_valid (div_vld),
		.out_meta  (div_meta),
		.quo       (div_quo)
	);

	// sign and output
	logic [qfv_pkg::QUO_W+15:0] ext [4];
	logic [63:0] data_d;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ext[i] = {16'd0, div_quo[i]};
			if (div_meta.neg[i]) ext[i] = -ext[i];
			data_d[16*i +: 16] = div_meta.deg ? 16'd0 : ext[i][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q                   <= data_d;
			out_user_q[qfv_pkg::USR_OPP] <= div_meta.opp && !div_meta.deg;
			out_user_q[qfv_pkg::USR_DEG] <= div_meta.deg;
		end
	end
endmodule

// ===== rtl/qfv_checker.sv =====
// Port-level checks for the quaternion unit and their binding.
`timescale 1ns / 1ps
module qfv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transfer changed while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[qfv_pkg::USR_DEG] |-> m_tdata == 64'd0)
		else $error("degenerate result carries nonzero parts");

	a_deg_opp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[qfv_pkg::USR_DEG] |-> !m_tuser[qfv_pkg::USR_OPP])
		else $error("degenerate and opposite flags both set");

	a_opp_real: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[qfv_pkg::USR_OPP] |-> m_tdata[15:0] == 16'd0)
		else $error("opposite branch with nonzero real part");
endmodule

bind quaternion_from_two_vectors_unit qfv_checker u_qfv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
